[hdl/pfdc_pkg.sv]
// ----------------------------------------------------------------------------
// pfdc_pkg: shared types and constants for the pwm capture block
// Sizes, function codes, divider operations and the controller/datapath
// command and status records.
// ----------------------------------------------------------------------------
package pfdc_pkg;

  // block sizes
  localparam int CHANNELS     = 6;
  localparam int AVG_DEPTH    = 2;
  localparam int EDGES_NEEDED = 2;

  // field widths
  localparam int STAMP_W = 32;
  localparam int CHAN_W  = 3;
  localparam int DUTY_W  = 7;
  localparam int FUNC_W  = 2;

  // derived widths
  localparam int CHI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int FILL_W = $clog2(AVG_DEPTH + 1);
  localparam int SUM_W  = STAMP_W + $clog2(AVG_DEPTH);
  // 100 * high + period - 1 needs 40 bits
  localparam int DIV_W  = 40;
  localparam int CNT_W  = $clog2(DIV_W + 1);

  // register reset and duty limits
  localparam logic [STAMP_W-1:0] TIMER_PERIOD_RESET = 32'd80000000;
  localparam int DUTY_MIN = 2;
  localparam int DUTY_MAX = 99;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START   = 2'd0,
    FUNC_EDGE    = 2'd1,
    FUNC_TIMEOUT = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    DIV_FREQ,
    DIV_DUTY,
    DIV_AVG_F,
    DIV_AVG_D
  } div_op_t;

  typedef struct packed {
    logic    load_in;
    logic    open_win;
    logic    record_fall;
    logic    record_rise;
    logic    close_win;
    logic    calc_span;
    logic    calc_scale;
    logic    div_start;
    div_op_t div_op;
    logic    push;
    logic    sum_init;
    logic    sum_step;
    logic    sum_duty;
    logic    emit_timeout;
    logic    emit_result;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              chan_ok;
    logic              rising;
    logic              win_open;
    logic              rise_last;
    logic              period_zero;
    logic              div_done;
    logic              sum_f_done;
    logic              sum_d_done;
    logic              duty_empty;
  } status_t;

endpackage

[hdl/pfdc_div.sv]
// ----------------------------------------------------------------------------
// pfdc_div: shared iterative divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfdc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pfdc_pkg::DIV_W-1:0] dividend,
  input  logic [31:0]                divisor,
  output logic                       done,
  output logic [pfdc_pkg::DIV_W-1:0] quotient
);

  logic                       busy;
  logic [pfdc_pkg::CNT_W-1:0] cnt;
  logic [31:0]                rem;
  logic [31:0]                dsr;
  logic [pfdc_pkg::DIV_W-1:0] quo;
  logic [32:0]                rs;
  logic [32:0]                trial;
  logic                       ge;

  // one restoring step
  always_comb begin
    rs    = {rem, quo[pfdc_pkg::DIV_W-1]};
    trial = rs - {1'b0, dsr};
    ge    = (rs >= {1'b0, dsr});
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= pfdc_pkg::CNT_W'(pfdc_pkg::DIV_W);
      end else if (busy) begin
        cnt  <= cnt - 1'b1;
        busy <= (cnt != pfdc_pkg::CNT_W'(1));
        done <= (cnt == pfdc_pkg::CNT_W'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? trial[31:0] : rs[31:0];
      quo <= {quo[pfdc_pkg::DIV_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

[hdl/pfdc_datapath.sv]
// ----------------------------------------------------------------------------
// pfdc_datapath: capture state, arithmetic and histories
// Holds the window state, edge stamps, per-channel averaging histories,
// the shared divider and the result register.
// ----------------------------------------------------------------------------
module pfdc_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  pfdc_pkg::cmd_t                 cmd,
  output pfdc_pkg::status_t              status,
  input  logic                           cfg_we,
  input  logic [pfdc_pkg::STAMP_W-1:0]   cfg_data,
  input  logic [39:0]                    in_tdata,
  input  logic [2:0]                     in_tuser,
  output logic [47:0]                    out_tdata,
  output logic [0:0]                     out_tuser
);

  // register
  logic [31:0] timer_period;

  // captured input word
  logic [1:0]  in_func;
  logic [2:0]  in_channel;
  logic        in_rising;
  logic [31:0] in_stamp;

  // window state
  logic        window_open;
  logic [2:0]  active_channel;
  logic [1:0]  rise_count;
  logic [31:0] prev_rise_stamp;
  logic [31:0] last_rise_stamp;
  logic [31:0] last_fall_stamp;

  // measurement
  logic [pfdc_pkg::CHI_W-1:0]  res_ch;
  logic [31:0]                 period;
  logic [31:0]                 high_time;
  logic [pfdc_pkg::DIV_W-1:0]  h100;
  logic [pfdc_pkg::DIV_W-1:0]  pm1;
  logic [pfdc_pkg::DIV_W-1:0]  hx;
  logic [31:0]                 f_val;
  logic [6:0]                  d_val;
  logic                        duty_ok;
  logic [31:0]                 avg_f;
  logic [6:0]                  avg_d;

  // histories
  logic [31:0] freq_hist [pfdc_pkg::CHANNELS][pfdc_pkg::AVG_DEPTH];
  logic [6:0]  duty_hist [pfdc_pkg::CHANNELS][pfdc_pkg::AVG_DEPTH];
  logic [pfdc_pkg::FILL_W-1:0] freq_fill [pfdc_pkg::CHANNELS];
  logic [pfdc_pkg::FILL_W-1:0] duty_fill [pfdc_pkg::CHANNELS];
  logic [pfdc_pkg::POS_W-1:0]  freq_pos  [pfdc_pkg::CHANNELS];
  logic [pfdc_pkg::POS_W-1:0]  duty_pos  [pfdc_pkg::CHANNELS];

  // averaging sum
  logic [pfdc_pkg::SUM_W-1:0]  acc;
  logic [pfdc_pkg::FILL_W-1:0] idx;
  logic [pfdc_pkg::FILL_W-1:0] sel_fill;
  logic [31:0]                 entry;

  // divider
  logic [pfdc_pkg::DIV_W-1:0]  dividend;
  logic [31:0]                 divisor;
  logic                        div_done;
  logic [pfdc_pkg::DIV_W-1:0]  quotient;
  pfdc_pkg::div_op_t           op_q;

  // result register
  logic [2:0]  out_channel;
  logic [31:0] out_freq;
  logic [6:0]  out_duty;
  logic        out_timed_out;

  // wrap-corrected distance from b to a
  function automatic logic [31:0] span(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] tp);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, tp};
    if (a >= b) begin
      return a - b;
    end
    return (s > {1'b0, b}) ? 32'(s - {1'b0, b}) : '0;
  endfunction

  // ring position advance
  function automatic logic [pfdc_pkg::POS_W-1:0] pos_step(
    input logic [pfdc_pkg::POS_W-1:0] p);
    logic [pfdc_pkg::POS_W:0] n;
    n = {1'b0, p} + 1'b1;
    return (n >= (pfdc_pkg::POS_W + 1)'(pfdc_pkg::AVG_DEPTH)) ? '0 :
           n[pfdc_pkg::POS_W-1:0];
  endfunction

  // timer period register
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period <= pfdc_pkg::TIMER_PERIOD_RESET;
    end else if (cfg_we) begin
      timer_period <= cfg_data;
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_func    <= in_tuser[1:0];
      in_rising  <= in_tuser[2];
      in_channel <= in_tdata[2:0];
      in_stamp   <= in_tdata[34:3];
    end
  end

  // window and edge stamps
  always_ff @(posedge clk) begin
    if (rst) begin
      window_open     <= 1'b0;
      active_channel  <= '0;
      rise_count      <= '0;
      prev_rise_stamp <= '0;
      last_rise_stamp <= '0;
      last_fall_stamp <= '0;
    end else begin
      if (cmd.open_win) begin
        window_open    <= 1'b1;
        active_channel <= in_channel;
        rise_count     <= '0;
      end
      if (cmd.record_fall) begin
        last_fall_stamp <= in_stamp;
      end
      if (cmd.record_rise) begin
        prev_rise_stamp <= last_rise_stamp;
        last_rise_stamp <= in_stamp;
        rise_count      <= rise_count + 2'd1;
      end
      if (cmd.close_win) begin
        window_open <= 1'b0;
      end
    end
  end

  // period, high time, scaled numerator
  assign hx = pfdc_pkg::DIV_W'(high_time);

  always_ff @(posedge clk) begin
    if (cmd.calc_span) begin
      period    <= span(last_rise_stamp, prev_rise_stamp, timer_period);
      high_time <= span(last_fall_stamp, prev_rise_stamp, timer_period);
      res_ch    <= ({1'b0, active_channel} < 4'(pfdc_pkg::CHANNELS)) ?
                   active_channel[pfdc_pkg::CHI_W-1:0] : '0;
    end
    if (cmd.calc_scale) begin
      // x100 as 64 + 32 + 4
      h100    <= (hx << 6) + (hx << 5) + (hx << 2);
      pm1     <= pfdc_pkg::DIV_W'(period) - pfdc_pkg::DIV_W'(1);
      f_val   <= '1;
      duty_ok <= 1'b0;
      avg_d   <= '0;
    end
    if (div_done) begin
      unique case (op_q)
        pfdc_pkg::DIV_FREQ: f_val <= quotient[31:0];
        pfdc_pkg::DIV_DUTY: begin
          d_val   <= quotient[6:0];
          duty_ok <= (quotient >= pfdc_pkg::DIV_W'(pfdc_pkg::DUTY_MIN)) &&
                     (quotient <= pfdc_pkg::DIV_W'(pfdc_pkg::DUTY_MAX));
        end
        pfdc_pkg::DIV_AVG_F: avg_f <= quotient[31:0];
        pfdc_pkg::DIV_AVG_D: avg_d <= quotient[6:0];
        default: ;
      endcase
    end
  end

  // divider operand select
  always_comb begin
    unique case (cmd.div_op)
      pfdc_pkg::DIV_FREQ: begin
        dividend = pfdc_pkg::DIV_W'(timer_period);
        divisor  = period;
      end
      pfdc_pkg::DIV_DUTY: begin
        dividend = h100 + pm1;
        divisor  = period;
      end
      pfdc_pkg::DIV_AVG_F: begin
        dividend = pfdc_pkg::DIV_W'(acc);
        divisor  = 32'(freq_fill[res_ch]);
      end
      default: begin
        dividend = pfdc_pkg::DIV_W'(acc);
        divisor  = 32'(duty_fill[res_ch]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      op_q <= cmd.div_op;
    end
  end

  pfdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // history entries
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      freq_hist[res_ch][freq_pos[res_ch]] <= f_val;
      if (duty_ok) begin
        duty_hist[res_ch][duty_pos[res_ch]] <= d_val;
      end
    end
  end

  // history positions and fill counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < pfdc_pkg::CHANNELS; c++) begin
        freq_fill[c] <= '0;
        duty_fill[c] <= '0;
        freq_pos[c]  <= '0;
        duty_pos[c]  <= '0;
      end
    end else if (cmd.push) begin
      freq_pos[res_ch] <= pos_step(freq_pos[res_ch]);
      if (freq_fill[res_ch] < pfdc_pkg::FILL_W'(pfdc_pkg::AVG_DEPTH)) begin
        freq_fill[res_ch] <= freq_fill[res_ch] + 1'b1;
      end
      if (duty_ok) begin
        duty_pos[res_ch] <= pos_step(duty_pos[res_ch]);
        if (duty_fill[res_ch] < pfdc_pkg::FILL_W'(pfdc_pkg::AVG_DEPTH)) begin
          duty_fill[res_ch] <= duty_fill[res_ch] + 1'b1;
        end
      end
    end
  end

  // sum of filled entries, one per cycle
  always_comb begin
    sel_fill = cmd.sum_duty ? duty_fill[res_ch] : freq_fill[res_ch];
    entry    = cmd.sum_duty ? 32'(duty_hist[res_ch][idx[pfdc_pkg::POS_W-1:0]]) :
               freq_hist[res_ch][idx[pfdc_pkg::POS_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_init) begin
      acc <= '0;
      idx <= '0;
    end else if (cmd.sum_step && (idx != sel_fill)) begin
      acc <= acc + pfdc_pkg::SUM_W'(entry);
      idx <= idx + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit_timeout) begin
      out_channel   <= active_channel;
      out_freq      <= '0;
      out_duty      <= '0;
      out_timed_out <= 1'b1;
    end else if (cmd.emit_result) begin
      out_channel   <= 3'(res_ch);
      out_freq      <= avg_f;
      out_duty      <= avg_d;
      out_timed_out <= 1'b0;
    end
  end

  assign out_tdata = {6'b0, out_duty, out_freq, out_channel};
  assign out_tuser = out_timed_out;

  // status to controller
  always_comb begin
    status.func        = in_func;
    status.chan_ok     = ({1'b0, in_channel} < 4'(pfdc_pkg::CHANNELS));
    status.rising      = in_rising;
    status.win_open    = window_open;
    status.rise_last   = (2'(rise_count + 2'd1) >= 2'(pfdc_pkg::EDGES_NEEDED));
    status.period_zero = (period == '0);
    status.div_done    = div_done;
    status.sum_f_done  = (idx == freq_fill[res_ch]);
    status.sum_d_done  = (idx == duty_fill[res_ch]);
    status.duty_empty  = (duty_fill[res_ch] == '0);
  end

endmodule

[hdl/pfdc_ctrl.sv]
// ----------------------------------------------------------------------------
// pfdc_ctrl: measurement sequencer
// Decodes each word, then for a finished window steps the datapath through span,
// up to four divides, history update, averaging and result hand-off.
// ----------------------------------------------------------------------------
module pfdc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_valid,
  output logic               s_ready,
  input  logic               m_ready,
  output logic               m_valid,
  input  pfdc_pkg::status_t  status,
  output pfdc_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TIMEOUT,
    ST_SPAN,
    ST_SCALE,
    ST_DIV_F,
    ST_WAIT_F,
    ST_DIV_D,
    ST_WAIT_D,
    ST_PUSH,
    ST_SUM_F,
    ST_WAIT_AF,
    ST_SUM_D,
    ST_WAIT_AD,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_valid || m_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_op = pfdc_pkg::DIV_FREQ;
    s_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        priority if (status.func == pfdc_pkg::FUNC_START) begin
          cmd.open_win = status.chan_ok;
        end else if (status.func == pfdc_pkg::FUNC_TIMEOUT && status.win_open) begin
          cmd.close_win = 1'b1;
          state_next    = ST_TIMEOUT;
        end else if (status.func == pfdc_pkg::FUNC_EDGE && status.win_open) begin
          if (status.rising) begin
            cmd.record_rise = 1'b1;
            if (status.rise_last) begin
              cmd.close_win = 1'b1;
              state_next    = ST_SPAN;
            end
          end else begin
            cmd.record_fall = 1'b1;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_TIMEOUT: begin
        if (out_free) begin
          cmd.emit_timeout = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      ST_SPAN: begin
        cmd.calc_span = 1'b1;
        state_next    = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.calc_scale = 1'b1;
        state_next     = status.period_zero ? ST_PUSH : ST_DIV_F;
      end
      ST_DIV_F: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = pfdc_pkg::DIV_FREQ;
        state_next    = ST_WAIT_F;
      end
      ST_WAIT_F: begin
        if (status.div_done) begin
          state_next = ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = pfdc_pkg::DIV_DUTY;
        state_next    = ST_WAIT_D;
      end
      ST_WAIT_D: begin
        if (status.div_done) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push     = 1'b1;
        cmd.sum_init = 1'b1;
        state_next   = ST_SUM_F;
      end
      ST_SUM_F: begin
        if (status.sum_f_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = pfdc_pkg::DIV_AVG_F;
          state_next    = ST_WAIT_AF;
        end else begin
          cmd.sum_step = 1'b1;
        end
      end
      ST_WAIT_AF: begin
        if (status.div_done) begin
          if (status.duty_empty) begin
            state_next = ST_EMIT;
          end else begin
            cmd.sum_init = 1'b1;
            state_next   = ST_SUM_D;
          end
        end
      end
      ST_SUM_D: begin
        cmd.sum_duty = 1'b1;
        if (status.sum_d_done) begin
          cmd.div_start = 1'b1;
          cmd.div_op    = pfdc_pkg::DIV_AVG_D;
          state_next    = ST_WAIT_AD;
        end else begin
          cmd.sum_step = 1'b1;
        end
      end
      ST_WAIT_AD: begin
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit_timeout || cmd.emit_result) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/pwm_frequency_duty_capture.sv]
// ----------------------------------------------------------------------------
// pwm_frequency_duty_capture: pwm frequency and duty measurement
// Start, falling edge, first rising edge and ignored words are handled in decode;
//   a timeout also waits for the output register to be free.
// A second rising edge runs four passes through the shared divider and the
//   history sums; fewer divides when the period is zero (no frequency or duty
//   divide) or the duty history is empty (no duty average); one word at a time.
// Reset (rst, synchronous) closes the window, empties all histories and
//   reloads timer_period with 80000000; history contents are not cleared.
// ----------------------------------------------------------------------------
module pwm_frequency_duty_capture (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // channel[2:0], stamp[34:3], zero fill
  input  logic [2:0]  s_axis_tuser,   // func[1:0], rising[2]
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_channel[2:0], frequency[34:3],
                                      // duty_percent[41:35], zero fill
  output logic [0:0]  m_axis_tuser,   // timed_out[0]
  // timer_period write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  pfdc_pkg::cmd_t    cmd;
  pfdc_pkg::status_t status;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  pfdc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_ready (m_axis_tready),
    .m_valid (m_axis_tvalid),
    .status  (status),
    .cmd     (cmd)
  );

  pfdc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .in_tdata  (s_axis_tdata),
    .in_tuser  (s_axis_tuser),
    .out_tdata (m_axis_tdata),
    .out_tuser (m_axis_tuser)
  );

endmodule

[hdl/pfdc_checker.sv]
// ----------------------------------------------------------------------------
// pfdc_checker: port-level checks for the pwm capture block
// Watches the result channel for stability, value ranges and reset.
// ----------------------------------------------------------------------------
module pfdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // timeout results carry zero frequency and duty
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[41:3] == 39'd0)
    else $error("timeout result with nonzero measurement");

  // averaged duty does not exceed the accepted maximum
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[41:35] <= 7'(pfdc_pkg::DUTY_MAX))
    else $error("duty above accepted range");

  // channel of a result exists
  a_channel_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> {1'b0, m_axis_tdata[2:0]} < 4'(pfdc_pkg::CHANNELS))
    else $error("result on nonexistent channel");

  // no result word right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind pwm_frequency_duty_capture pfdc_checker u_checker (.*);

[tb/tb_pwm_frequency_duty_capture.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pwm_frequency_duty_capture: self-checking bench for pwm capture
// A short table of start, edge, timeout and unused-code words is followed by random
// measurement windows under several timer periods. Every result word is
// checked field by field against a literal value or an in-bench model of the capture logic,
// with random idle bursts on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_pwm_frequency_duty_capture;

  localparam logic [pfdc_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS = 90;
  localparam int TAIL_CYCLES = 250;
  localparam int CFG_SETTLE  = 8;

  typedef struct packed {
    logic                         timed_out;
    logic [pfdc_pkg::DUTY_W-1:0]  duty;
    logic [pfdc_pkg::STAMP_W-1:0] freq;
    logic [pfdc_pkg::CHAN_W-1:0]  chan;
  } meas_t;

  typedef struct packed {
    bit                           lit;
    meas_t                        lit_res;
    logic [pfdc_pkg::FUNC_W-1:0]  func;
    logic [pfdc_pkg::CHAN_W-1:0]  chan;
    logic                         rising;
    logic [pfdc_pkg::STAMP_W-1:0] stamp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // channel[2:0], stamp[34:3], zero fill
  logic [2:0]  s_axis_tuser = '0;   // func[1:0], rising[2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // out_channel[2:0], frequency[34:3],
                                    // duty_percent[41:35], zero fill
  logic [0:0]  m_axis_tuser;        // timed_out[0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // capture model state
  logic [pfdc_pkg::STAMP_W-1:0] period_cfg;
  bit                           win_open;
  logic [pfdc_pkg::CHAN_W-1:0]  win_chan;
  logic [1:0]                   rises;
  logic [pfdc_pkg::STAMP_W-1:0] prev_rise;
  logic [pfdc_pkg::STAMP_W-1:0] last_rise;
  logic [pfdc_pkg::STAMP_W-1:0] last_fall;
  logic [pfdc_pkg::STAMP_W-1:0] freq_hist [pfdc_pkg::CHANNELS][pfdc_pkg::AVG_DEPTH];
  logic [pfdc_pkg::DUTY_W-1:0]  duty_hist [pfdc_pkg::CHANNELS][pfdc_pkg::AVG_DEPTH];
  int                           freq_fill [pfdc_pkg::CHANNELS];
  int                           duty_fill [pfdc_pkg::CHANNELS];
  int                           freq_pos  [pfdc_pkg::CHANNELS];
  int                           duty_pos  [pfdc_pkg::CHANNELS];

  meas_t     pending_meas[$];
  stim_row_t table_rows[$];
  int        failures = 0;
  int        cycle_count = 0;
  int        busy_items;
  bit        quiet = 1'b0;
  bit        hold_req = 1'b0;
  bit        hold_done = 1'b0;
  bit        drained = 1'b0;
  meas_t     got_meas;
  meas_t     want_meas;
  logic [pfdc_pkg::STAMP_W-1:0] phase_period [5];

  pwm_frequency_duty_capture dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic stim_row_t item(input logic [pfdc_pkg::FUNC_W-1:0] f,
                                     input logic [pfdc_pkg::CHAN_W-1:0] c,
                                     input logic r,
                                     input logic [pfdc_pkg::STAMP_W-1:0] s);
    stim_row_t w;
    w = '0;
    w.func = f;
    w.chan = c;
    w.rising = r;
    w.stamp = s;
    return w;
  endfunction

  function automatic meas_t meas(input logic [pfdc_pkg::CHAN_W-1:0] c,
                                 input logic [pfdc_pkg::STAMP_W-1:0] f,
                                 input logic [pfdc_pkg::DUTY_W-1:0] d, input logic t);
    meas_t m;
    m.chan = c;
    m.freq = f;
    m.duty = d;
    m.timed_out = t;
    return m;
  endfunction

  function automatic stim_row_t lit_row(input stim_row_t w, input meas_t m);
    stim_row_t r;
    r = w;
    r.lit = 1'b1;
    r.lit_res = m;
    return r;
  endfunction

  // random field values
  function automatic logic [pfdc_pkg::CHAN_W-1:0] any_chan();
    return pfdc_pkg::CHAN_W'($urandom_range(0, 7));
  endfunction

  function automatic logic any_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // elapsed timer counts from b to a, one wrap allowed
  function automatic logic [63:0] wrap_span(input logic [pfdc_pkg::STAMP_W-1:0] a,
                                            input logic [pfdc_pkg::STAMP_W-1:0] b);
    logic [63:0] s;
    if (a >= b) return {32'd0, a} - {32'd0, b};
    s = {32'd0, a} + {32'd0, period_cfg};
    return (s > {32'd0, b}) ? s - {32'd0, b} : 64'd0;
  endfunction

  task automatic reset_capture_model();
    period_cfg = pfdc_pkg::TIMER_PERIOD_RESET;
    win_open = 1'b0;
    win_chan = '0;
    rises = '0;
    prev_rise = '0;
    last_rise = '0;
    last_fall = '0;
    for (int c = 0; c < pfdc_pkg::CHANNELS; c++) begin
      freq_fill[c] = 0;
      duty_fill[c] = 0;
      freq_pos[c] = 0;
      duty_pos[c] = 0;
    end
  endtask

  // advance the capture model by one word; has_res when a window finishes
  task automatic predict_capture(input stim_row_t w, output bit has_res, output meas_t res,
                                 output bit counts);
    logic [63:0] period, high_t, dq, sum;
    logic [pfdc_pkg::STAMP_W-1:0] fval;
    int ch;
    has_res = 1'b0;
    counts = 1'b0;
    res = '0;
    if (w.func == pfdc_pkg::FUNC_START) begin
      if (w.chan < pfdc_pkg::CHANNELS) begin
        win_open = 1'b1;
        win_chan = w.chan;
        rises = '0;
        counts = 1'b1;
      end
    end else if (w.func == pfdc_pkg::FUNC_TIMEOUT) begin
      if (win_open) begin
        win_open = 1'b0;
        res = meas(win_chan, '0, '0, 1'b1);
        has_res = 1'b1;
        counts = 1'b1;
      end
    end else if (w.func == pfdc_pkg::FUNC_EDGE && win_open) begin
      counts = 1'b1;
      if (!w.rising) begin
        last_fall = w.stamp;
      end else begin
        prev_rise = last_rise;
        last_rise = w.stamp;
        rises = rises + 2'd1;
        if (rises >= pfdc_pkg::EDGES_NEEDED) begin
          win_open = 1'b0;
          ch = int'(win_chan);
          period = wrap_span(last_rise, prev_rise);
          high_t = wrap_span(last_fall, prev_rise);
          // zero period saturates frequency and skips duty
          fval = '1;
          if (period != 0) fval = pfdc_pkg::STAMP_W'({32'd0, period_cfg} / period);
          freq_hist[ch][freq_pos[ch]] = fval;
          freq_pos[ch] = (freq_pos[ch] + 1 >= pfdc_pkg::AVG_DEPTH) ? 0 : freq_pos[ch] + 1;
          if (freq_fill[ch] < pfdc_pkg::AVG_DEPTH) freq_fill[ch]++;
          if (period != 0) begin
            dq = (64'd100 * high_t + period - 64'd1) / period;
            if (dq >= pfdc_pkg::DUTY_MIN && dq <= pfdc_pkg::DUTY_MAX) begin
              duty_hist[ch][duty_pos[ch]] = dq[pfdc_pkg::DUTY_W-1:0];
              duty_pos[ch] = (duty_pos[ch] + 1 >= pfdc_pkg::AVG_DEPTH) ? 0 :
                             duty_pos[ch] + 1;
              if (duty_fill[ch] < pfdc_pkg::AVG_DEPTH) duty_fill[ch]++;
            end
          end
          res.chan = pfdc_pkg::CHAN_W'(ch);
          sum = 0;
          for (int i = 0; i < freq_fill[ch]; i++) sum += freq_hist[ch][i];
          res.freq = pfdc_pkg::STAMP_W'(sum / freq_fill[ch]);
          sum = 0;
          for (int i = 0; i < duty_fill[ch]; i++) sum += duty_hist[ch][i];
          res.duty = (duty_fill[ch] == 0) ? '0 : pfdc_pkg::DUTY_W'(sum / duty_fill[ch]);
          has_res = 1'b1;
        end
      end
    end
  endtask

  // offer one input word, log its expected result, then maybe idle
  task automatic send_item(input stim_row_t w);
    bit    has_res, counts;
    meas_t res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, w.stamp, w.chan};
    s_axis_tuser <= {w.rising, w.func};
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    predict_capture(w, has_res, res, counts);
    if (has_res) pending_meas.push_back(w.lit ? w.lit_res : res);
    if (counts) busy_items++;
    @(posedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // register write once the block has drained
  task automatic write_timer_period(input logic [pfdc_pkg::STAMP_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_meas.size() != 0);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    period_cfg = value;
  endtask

  // one well-formed window with random timing, sometimes broken
  task automatic run_measurement(input logic [pfdc_pkg::STAMP_W-1:0] tp);
    logic [pfdc_pkg::CHAN_W-1:0]  ch;
    logic [pfdc_pkg::STAMP_W-1:0] r0, lim;
    logic [63:0]                  p, hi;
    ch = ($urandom_range(0, 9) == 0) ?
         pfdc_pkg::CHAN_W'($urandom_range(pfdc_pkg::CHANNELS, 7)) :
         pfdc_pkg::CHAN_W'($urandom_range(0, pfdc_pkg::CHANNELS - 1));
    send_item(item(pfdc_pkg::FUNC_START, ch, any_bit(), $urandom));
    if ($urandom_range(0, 9) == 0) begin
      send_item(item(pfdc_pkg::FUNC_TIMEOUT, any_chan(), any_bit(), $urandom));
      return;
    end
    if ($urandom_range(0, 5) == 0)
      send_item(item(pfdc_pkg::FUNC_EDGE, any_chan(), 1'b0, $urandom));
    r0 = $urandom_range(0, tp - 1);
    lim = (tp - 1 < 5000) ? tp - 1 : 5000;
    if ($urandom_range(0, 19) == 0) p = 0;
    else if ($urandom_range(0, 1) == 0) p = 64'($urandom_range(1, tp - 1));
    else p = 64'($urandom_range(1, lim));
    hi = (p * $urandom_range(0, 100)) / 100;
    send_item(item(pfdc_pkg::FUNC_EDGE, any_chan(), 1'b1, r0));
    if ($urandom_range(0, 4) != 0)
      send_item(item(pfdc_pkg::FUNC_EDGE, any_chan(), 1'b0,
                     pfdc_pkg::STAMP_W'(({32'd0, r0} + hi) % tp)));
    if ($urandom_range(0, 7) == 0)
      send_item(item(pfdc_pkg::FUNC_TIMEOUT, any_chan(), any_bit(), $urandom));
    else
      send_item(item(pfdc_pkg::FUNC_EDGE, any_chan(), 1'b1,
                     pfdc_pkg::STAMP_W'(({32'd0, r0} + p) % tp)));
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // result word checker, sampled between edges
  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_meas = meas(m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[41:35],
                      m_axis_tuser[0]);
      if (pending_meas.size() == 0) begin
        failures++;
        $display("%0t: unexpected result word, expected none, actual %0h", $time, got_meas);
      end else begin
        want_meas = pending_meas.pop_front();
        check_field("out_channel", want_meas.chan, got_meas.chan);
        check_field("frequency", want_meas.freq, got_meas.freq);
        check_field("duty_percent", want_meas.duty, got_meas.duty);
        check_field("timed_out", want_meas.timed_out, got_meas.timed_out);
      end
    end
  end

  // output stall: random bursts, plus one long hold on request
  initial begin
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    reset_capture_model();
    phase_period[0] = 32'd2;
    phase_period[1] = 32'hFFFF_FFFF;
    phase_period[2] = 32'd1000;
    phase_period[3] = $urandom_range(32'hFFFF_FFFF, 2);
    phase_period[4] = pfdc_pkg::TIMER_PERIOD_RESET;

    // start beyond the channel count leaves the window closed
    table_rows.push_back(item(pfdc_pkg::FUNC_START, 3'd7, 1'b1, 32'hFFFF_FFFF));
    table_rows.push_back(item(pfdc_pkg::FUNC_TIMEOUT, 3'd0, 1'b0, 32'd0));
    table_rows.push_back(item(pfdc_pkg::FUNC_EDGE, 3'd7, 1'b1, 32'hFFFF_FFFF));
    table_rows.push_back(item(FUNC_UNUSED, 3'd7, 1'b1, 32'hFFFF_FFFF));
    // timeout on an open window
    table_rows.push_back(item(pfdc_pkg::FUNC_START, 3'd0, 1'b0, 32'd0));
    table_rows.push_back(lit_row(item(pfdc_pkg::FUNC_TIMEOUT, 3'd0, 1'b0, 32'd0),
                                 meas(3'd0, 32'd0, 7'd0, 1'b1)));
    table_rows.push_back(item(pfdc_pkg::FUNC_EDGE, 3'd0, 1'b0, 32'd5));
    // clean 100 Hz, 50 percent at the reset timer period
    table_rows.push_back(item(pfdc_pkg::FUNC_START, 3'd5, 1'b0, 32'd0));
    table_rows.push_back(item(pfdc_pkg::FUNC_EDGE, 3'd0, 1'b1, 32'd0));
    table_rows.push_back(item(pfdc_pkg::FUNC_EDGE, 3'd0, 1'b0, 32'd400000));
    table_rows.push_back(lit_row(item(pfdc_pkg::FUNC_EDGE, 3'd0, 1'b1, 32'd800000),
                                 meas(3'd5, 32'd100, 7'd50, 1'b0)));
    // zero period saturates frequency, duty history stays empty
    table_rows.push_back(item(pfdc_pkg::FUNC_START, 3'd1, 1'b0, 32'd0));
    table_rows.push_back(item(pfdc_pkg::FUNC_EDGE, 3'd0, 1'b1, 32'd1234));
    table_rows.push_back(lit_row(item(pfdc_pkg::FUNC_EDGE, 3'd0, 1'b1, 32'd1234),
                                 meas(3'd1, 32'hFFFF_FFFF, 7'd0, 1'b0)));
    // restart on a new channel while open, unused code in an open window
    table_rows.push_back(item(pfdc_pkg::FUNC_START, 3'd2, 1'b0, 32'd0));
    table_rows.push_back(item(pfdc_pkg::FUNC_EDGE, 3'd0, 1'b1, 32'd10));
    table_rows.push_back(item(pfdc_pkg::FUNC_START, 3'd3, 1'b0, 32'd0));
    table_rows.push_back(item(FUNC_UNUSED, 3'd0, 1'b0, 32'd0));
    table_rows.push_back(item(pfdc_pkg::FUNC_EDGE, 3'd0, 1'b1, 32'd20));
    table_rows.push_back(item(pfdc_pkg::FUNC_EDGE, 3'd0, 1'b0, 32'd25));
    table_rows.push_back(item(pfdc_pkg::FUNC_EDGE, 3'd0, 1'b1, 32'd30));
    // full-scale stamps: frequency 0, duty of 100 dropped
    table_rows.push_back(item(pfdc_pkg::FUNC_START, 3'd4, 1'b0, 32'd0));
    table_rows.push_back(item(pfdc_pkg::FUNC_EDGE, 3'd0, 1'b1, 32'd0));
    table_rows.push_back(item(pfdc_pkg::FUNC_EDGE, 3'd0, 1'b0, 32'hFFFF_FFFF));
    table_rows.push_back(lit_row(item(pfdc_pkg::FUNC_EDGE, 3'd0, 1'b1, 32'hFFFF_FFFF),
                                 meas(3'd4, 32'd0, 7'd0, 1'b0)));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (table_rows[i]) send_item(table_rows[i]);

    // random windows under each timer period, last phase without idling
    for (int ph = 0; ph < 5; ph++) begin
      write_timer_period(phase_period[ph]);
      quiet = (ph == 4);
      busy_items = 0;
      while (busy_items < PHASE_ITEMS) begin
        if (ph == 1 && busy_items >= 40 && !hold_done) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        if (ph == 2 && busy_items >= 50 && !drained) begin
          s_axis_tvalid <= 1'b0;
          do @(posedge clk); while (pending_meas.size() != 0);
          drained = 1'b1;
        end
        if ($urandom_range(0, 5) == 0)
          send_item(item(pfdc_pkg::FUNC_W'($urandom_range(0, 3)), any_chan(), any_bit(),
                         $urandom));
        else
          run_measurement(phase_period[ph]);
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_meas.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
hdl/pfdc_pkg.sv
hdl/pfdc_div.sv
hdl/pfdc_datapath.sv
hdl/pfdc_ctrl.sv
hdl/pwm_frequency_duty_capture.sv
hdl/pfdc_checker.sv
tb/tb_pwm_frequency_duty_capture.sv
